// ===== rtl/core/rlid_pkg.sv =====
// rlid_pkg: shared constants, stage codes, register indexes and the
// command/status structs between the controller and the datapath.
// no dependencies
`default_nettype none
package rlid_pkg;

	localparam int STEP_BITS = 20;
	localparam int FRAC_BITS = 16;

	localparam int CNT_W   = STEP_BITS + 1;
	localparam int SUM_W   = 32 + STEP_BITS;
	localparam int LH_W    = 33 + STEP_BITS;
	localparam int DEN_W   = 35 + STEP_BITS;
	localparam int NUM_W   = 57 + STEP_BITS;
	localparam int PV_W    = 55;

	localparam int KI_W    = FRAC_BITS - 2;
	localparam int KI_Q    = ((2 ** FRAC_BITS) * 5 + 50) / 100;

	localparam int THIRD_SH  = STEP_BITS + 1;
	localparam int THIRD_MUL = (2 ** THIRD_SH) / 3 + 1;
	localparam int TH_W      = 2 * STEP_BITS;

	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_CNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RES_CNT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IND_CNT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCK_CUR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SQ_VOLT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 3'd5;

	localparam logic [2:0] STG_INIT  = 3'd0;
	localparam logic [2:0] STG_IDLE1 = 3'd1;
	localparam logic [2:0] STG_RES   = 3'd2;
	localparam logic [2:0] STG_IDLE2 = 3'd3;
	localparam logic [2:0] STG_IND   = 3'd4;
	localparam logic [2:0] STG_IDLE3 = 3'd5;
	localparam logic [2:0] STG_DONE  = 3'd6;

	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

	typedef struct packed {
		logic latch;
		logic step;
		logic sq_a;
		logic sq_b;
		logic sqrt_start;
		logic mag_acc;
		logic sel;
		logic pv;
		logic nlo;
		logic nhi;
		logic div_start;
		logic commit;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_res;
		logic is_ind;
		logic mag_en;
		logic stage_end;
		logic div_skip;
		logic sqrt_done;
		logic div_done;
	} status_t;

endpackage
`default_nettype wire

// ===== rtl/core/rlid_sqrt.sv =====
// rlid_sqrt: 64-bit floor square root, one result bit per cycle
// depends on nothing but clk and reset
`default_nettype none
module rlid_sqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic             done,
	output logic [31:0]      root
);

	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [35:0] rem_sh;
	logic [35:0] trial;
	logic        ge;

	assign rem_sh = {rem_q, rad_q[63:62]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
			root_q <= {root_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

// ===== rtl/core/rlid_div.sv =====
// rlid_div: saturating 32-bit quotient, restoring division one bit per cycle
// depends on rlid_pkg
`default_nettype none
module rlid_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [rlid_pkg::NUM_W-1:0]  num,
	input  wire logic [rlid_pkg::DEN_W-1:0]  den,
	output logic                             done,
	output logic [31:0]                      quo
);

	localparam int HI_W = rlid_pkg::NUM_W - 32;

	logic [rlid_pkg::DEN_W-1:0] rem_q;
	logic [rlid_pkg::DEN_W-1:0] den_q;
	logic [31:0]                low_q;
	logic [31:0]                quo_q;
	logic [4:0]                 cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [rlid_pkg::DEN_W-1:0] hi_x;
	logic                       sat;
	logic [rlid_pkg::DEN_W:0]   r2;
	logic                       ge;

	assign hi_x = {{(rlid_pkg::DEN_W - HI_W){1'b0}}, num[rlid_pkg::NUM_W-1:32]};
	assign sat  = hi_x >= den;
	assign r2   = {rem_q, low_q[31]};
	assign ge   = r2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !sat;
				done_q <= sat;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= hi_x;
			den_q <= den;
			low_q <= num[31:0];
			quo_q <= sat ? rlid_pkg::MAX32 : '0;
		end else if (busy_q) begin
			rem_q <= ge ? rlid_pkg::DEN_W'(r2 - {1'b0, den_q}) : r2[rlid_pkg::DEN_W-1:0];
			low_q <= {low_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

// ===== rtl/core/rlid_dp.sv =====
// rlid_dp: datapath with configuration, sample, stage state, accumulators,
// magnitude and division units and the output register; depends on rlid_pkg,
// rlid_sqrt and rlid_div
`default_nettype none
module rlid_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire rlid_pkg::cmd_t                  cmd,
	output rlid_pkg::status_t                    status,
	input  wire logic                            cfg_we,
	input  wire logic [rlid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rlid_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic signed [31:0]              id_meas,
	input  wire logic signed [31:0]              iq_meas,
	input  wire logic signed [31:0]              vd_meas,
	input  wire logic signed [31:0]              vq_meas,
	input  wire logic [30:0]                     bus_volt,
	output logic                                 drive_mode,
	output logic signed [31:0]                   vd_ref,
	output logic [2:0]                           stage_now,
	output logic                                 all_done,
	output logic [31:0]                          resistance,
	output logic [31:0]                          inductance_nh,
	output logic                                 div_fault
);

	localparam int S      = rlid_pkg::STEP_BITS;
	localparam int F      = rlid_pkg::FRAC_BITS;
	localparam int CW     = rlid_pkg::CNT_W;
	localparam int PROD_W = 34 + rlid_pkg::KI_W;

	logic [S-1:0]  idle_cnt_q, res_cnt_q, ind_cnt_q;
	logic [30:0]   lock_q, sqv_q;
	logic [23:0]   per_q;

	logic signed [31:0] id_q, iq_q, vd_q, vq_q;
	logic [30:0]        vb_q;

	logic [2:0]                     stage_q;
	logic [CW-1:0]                  cnt_q;
	logic [31:0]                    integ_q;
	logic [rlid_pkg::SUM_W-1:0]     vsum_q, csum_q;
	logic                           sign_q;
	logic signed [rlid_pkg::LH_W-1:0] low_q, high_q;
	logic [31:0]                    resr_q, indr_q;
	logic                           fault_q;
	logic                           mode_q;
	logic [31:0]                    vref_q;
	logic [rlid_pkg::TH_W-1:0]      third_q;
	logic [63:0]                    acc_q;
	logic [rlid_pkg::PV_W-1:0]      pv_q;
	logic [rlid_pkg::NUM_W-1:0]     n_q;

	logic [CW-1:0]                  cnt_inc;
	logic [31:0]                    integ_n;
	logic [31:0]                    vind;
	logic [31:0]                    sv32;
	logic signed [rlid_pkg::LH_W:0] diff;
	logic [rlid_pkg::LH_W-1:0]      id_x;
	logic                           is_res, is_ind, res_zero, ind_nonpos;
	logic signed [31:0]             a_s, b_s;
	logic [31:0]                    a_abs, b_abs;
	logic [rlid_pkg::NUM_W-1:0]     div_num;
	logic [rlid_pkg::DEN_W-1:0]     div_den;
	logic                           sqrt_done, div_done;
	logic [31:0]                    root, quo;
	logic [S-2:0]                   third;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cnt_q <= S'(1000);
			res_cnt_q  <= S'(20000);
			ind_cnt_q  <= S'(20000);
			lock_q     <= 31'd65536;
			sqv_q      <= 31'd65536;
			per_q      <= 24'd100000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rlid_pkg::CFG_IDLE_CNT: idle_cnt_q <= cfg_data[S-1:0];
				rlid_pkg::CFG_RES_CNT:  res_cnt_q  <= cfg_data[S-1:0];
				rlid_pkg::CFG_IND_CNT:  ind_cnt_q  <= cfg_data[S-1:0];
				rlid_pkg::CFG_LOCK_CUR: lock_q     <= cfg_data[30:0];
				rlid_pkg::CFG_SQ_VOLT:  sqv_q      <= cfg_data[30:0];
				rlid_pkg::CFG_PERIOD:   per_q      <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign is_res     = stage_q == rlid_pkg::STG_RES;
	assign is_ind     = stage_q == rlid_pkg::STG_IND;
	assign cnt_inc    = cnt_q + CW'(1);
	assign sv32       = {1'b0, sqv_q};
	assign vind       = sign_q ? (32'd0 - sv32) : sv32;
	assign id_x       = {{(rlid_pkg::LH_W-32){id_q[31]}}, id_q};
	assign diff       = $signed({low_q[rlid_pkg::LH_W-1], low_q})
	                  - $signed({high_q[rlid_pkg::LH_W-1], high_q});
	assign res_zero   = csum_q == '0;
	assign ind_nonpos = diff[rlid_pkg::LH_W] || (diff == '0);
	assign third      = third_q[rlid_pkg::TH_W-1:rlid_pkg::THIRD_SH];

	// integral controller, clamped to 0..bus
	always_comb begin
		logic signed [33:0]       err;
		logic signed [PROD_W-1:0] prod, incr, base, isum, vbx;
		err  = $signed({3'b000, lock_q}) - $signed({{2{id_q[31]}}, id_q});
		prod = $signed({{rlid_pkg::KI_W{err[33]}}, err})
		     * $signed({34'd0, rlid_pkg::KI_W'(rlid_pkg::KI_Q)});
		incr = (prod + $signed(PROD_W'(1) << (F - 1))) >>> F;
		base = (cnt_q == '0) ? '0 : $signed({{(PROD_W-32){1'b0}}, integ_q});
		isum = base + incr;
		vbx  = $signed({{(PROD_W-31){1'b0}}, vb_q});
		if (isum > vbx)
			integ_n = {1'b0, vb_q};
		else if (isum < 0)
			integ_n = '0;
		else
			integ_n = isum[31:0];
	end

	assign a_s   = cmd.sel ? id_q : vd_q;
	assign b_s   = cmd.sel ? iq_q : vq_q;
	assign a_abs = a_s[31] ? (32'd0 - a_s) : a_s;
	assign b_abs = b_s[31] ? (32'd0 - b_s) : b_s;

	assign div_num = is_res
		? rlid_pkg::NUM_W'({vsum_q, {(F+1){1'b0}}})
		: n_q;
	assign div_den = is_res
		? rlid_pkg::DEN_W'(rlid_pkg::DEN_W'(csum_q) + rlid_pkg::DEN_W'({csum_q, 1'b0}))
		: rlid_pkg::DEN_W'({diff, 1'b0});

	rlid_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (acc_q),
		.done     (sqrt_done),
		.root     (root)
	);

	rlid_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= rlid_pkg::STG_INIT;
			cnt_q   <= '0;
			integ_q <= '0;
			vsum_q  <= '0;
			csum_q  <= '0;
			sign_q  <= 1'b1;
			low_q   <= '0;
			high_q  <= '0;
			resr_q  <= '0;
			indr_q  <= '0;
			fault_q <= 1'b0;
		end else if (cmd.step) begin
			if (is_res) begin
				integ_q <= integ_n;
				cnt_q   <= cnt_inc;
			end else if (is_ind) begin
				if (sign_q)
					low_q <= low_q + $signed(id_x);
				else
					high_q <= high_q + $signed(id_x);
				sign_q <= !sign_q;
				cnt_q  <= cnt_inc;
			end else if (stage_q == rlid_pkg::STG_INIT) begin
				stage_q <= rlid_pkg::STG_IDLE1;
			end else if (stage_q == rlid_pkg::STG_IDLE1 || stage_q == rlid_pkg::STG_IDLE2
			          || stage_q == rlid_pkg::STG_IDLE3) begin
				if (cnt_inc > CW'(idle_cnt_q)) begin
					cnt_q   <= '0;
					stage_q <= stage_q + 3'd1;
				end else begin
					cnt_q <= cnt_inc;
				end
			end
		end else if (cmd.mag_acc) begin
			if (cmd.sel)
				csum_q <= csum_q + rlid_pkg::SUM_W'(root);
			else
				vsum_q <= vsum_q + rlid_pkg::SUM_W'(root);
		end else if (cmd.commit) begin
			cnt_q <= '0;
			if (is_res) begin
				resr_q  <= res_zero ? rlid_pkg::MAX32 : quo;
				fault_q <= fault_q | res_zero;
				vsum_q  <= '0;
				csum_q  <= '0;
				stage_q <= rlid_pkg::STG_IDLE2;
			end else begin
				indr_q  <= ind_nonpos ? rlid_pkg::MAX32 : quo;
				fault_q <= fault_q | ind_nonpos;
				sign_q  <= 1'b1;
				low_q   <= '0;
				high_q  <= '0;
				stage_q <= rlid_pkg::STG_IDLE3;
			end
		end
	end

	// sample, per item result and work registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			id_q <= id_meas;
			iq_q <= iq_meas;
			vd_q <= vd_meas;
			vq_q <= vq_meas;
			vb_q <= bus_volt;
		end
		if (cmd.step) begin
			third_q <= rlid_pkg::TH_W'(res_cnt_q) * rlid_pkg::TH_W'(rlid_pkg::THIRD_MUL);
			if (is_res) begin
				mode_q <= 1'b1;
				vref_q <= integ_n;
			end else if (is_ind) begin
				mode_q <= 1'b1;
				vref_q <= vind;
			end else begin
				mode_q <= 1'b0;
				vref_q <= '0;
			end
		end
		if (cmd.commit) begin
			mode_q <= 1'b0;
			vref_q <= '0;
		end
		if (cmd.sq_a)
			acc_q <= a_abs * a_abs;
		if (cmd.sq_b)
			acc_q <= acc_q + b_abs * b_abs;
		if (cmd.pv)
			pv_q <= rlid_pkg::PV_W'(sqv_q) * rlid_pkg::PV_W'(per_q);
		if (cmd.nlo)
			n_q <= rlid_pkg::NUM_W'(rlid_pkg::NUM_W'(pv_q[31:0]) * rlid_pkg::NUM_W'(cnt_q));
		if (cmd.nhi)
			n_q <= n_q + (rlid_pkg::NUM_W'(pv_q[rlid_pkg::PV_W-1:32] * cnt_q) << 32);
		if (cmd.out_load) begin
			drive_mode    <= mode_q;
			vd_ref        <= vref_q;
			stage_now     <= stage_q;
			all_done      <= stage_q[2] & stage_q[1];
			resistance    <= resr_q;
			inductance_nh <= indr_q;
			div_fault     <= fault_q;
		end
	end

	assign status.is_res    = is_res;
	assign status.is_ind    = is_ind;
	assign status.mag_en    = cnt_q > CW'(third);
	assign status.stage_end = (is_res && (cnt_q > CW'(res_cnt_q)))
	                       || (is_ind && (cnt_q > CW'(ind_cnt_q)));
	assign status.div_skip  = is_res ? res_zero : ind_nonpos;
	assign status.sqrt_done = sqrt_done;
	assign status.div_done  = div_done;

endmodule
`default_nettype wire

// ===== rtl/core/rlid_ctrl.sv =====
// rlid_ctrl: controller state machine sequencing one item through the datapath
// depends on rlid_pkg
`default_nettype none
module rlid_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire rlid_pkg::status_t  status,
	output rlid_pkg::cmd_t          cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_STEP = 4'd1;
	localparam logic [3:0] ST_CHK  = 4'd2;
	localparam logic [3:0] ST_SQA  = 4'd3;
	localparam logic [3:0] ST_SQB  = 4'd4;
	localparam logic [3:0] ST_SQRT = 4'd5;
	localparam logic [3:0] ST_SQW  = 4'd6;
	localparam logic [3:0] ST_END  = 4'd7;
	localparam logic [3:0] ST_PV   = 4'd8;
	localparam logic [3:0] ST_NLO  = 4'd9;
	localparam logic [3:0] ST_NHI  = 4'd10;
	localparam logic [3:0] ST_DIV  = 4'd11;
	localparam logic [3:0] ST_DIVW = 4'd12;
	localparam logic [3:0] ST_CMT  = 4'd13;
	localparam logic [3:0] ST_FIN  = 4'd14;

	logic [3:0] state_q, state_n;
	logic       sel_q;
	logic       out_valid_q;

	always_comb begin
		cmd     = '0;
		cmd.sel = sel_q;
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_n   = ST_STEP;
				end
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				state_n  = status.is_res ? ST_CHK : (status.is_ind ? ST_END : ST_FIN);
			end
			ST_CHK:  state_n = status.mag_en ? ST_SQA : ST_END;
			ST_SQA: begin
				cmd.sq_a = 1'b1;
				state_n  = ST_SQB;
			end
			ST_SQB: begin
				cmd.sq_b = 1'b1;
				state_n  = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_start = 1'b1;
				state_n        = ST_SQW;
			end
			ST_SQW: begin
				if (status.sqrt_done) begin
					cmd.mag_acc = 1'b1;
					state_n     = sel_q ? ST_END : ST_SQA;
				end
			end
			ST_END: begin
				if (!status.stage_end)
					state_n = ST_FIN;
				else if (status.div_skip)
					state_n = ST_CMT;
				else if (status.is_res)
					state_n = ST_DIV;
				else
					state_n = ST_PV;
			end
			ST_PV: begin
				cmd.pv  = 1'b1;
				state_n = ST_NLO;
			end
			ST_NLO: begin
				cmd.nlo = 1'b1;
				state_n = ST_NHI;
			end
			ST_NHI: begin
				cmd.nhi = 1'b1;
				state_n = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_start = 1'b1;
				state_n       = ST_DIVW;
			end
			ST_DIVW: begin
				if (status.div_done)
					state_n = ST_CMT;
			end
			ST_CMT: begin
				cmd.commit = 1'b1;
				state_n    = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.mag_acc)
				sel_q <= !sel_q;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/core/motor_rl_identification_sequencer_top.sv =====
// motor_rl_identification_sequencer_top: motor R/L identification sequencer
// depends on rlid_pkg, rlid_ctrl, rlid_dp (with rlid_sqrt, rlid_div)
//
// One input item is one control period sample (dq current, dq voltage, bus
// voltage); every item gives exactly one result item with the drive command,
// the stage and the identified resistance and inductance.
// Input and output use valid/ready. in_ready is high while the controller
// waits for a sample; one item is worked on at a time.
// Work per item depends on the stage: init, idle and done stages only step
// the stage state; inductance samples step the square wave; resistance
// samples step the integrator and, past the first third of the stage, sum
// the two dq magnitudes through two square root passes. A stage that ends
// with a division runs the restoring divider, which stops at once when the
// quotient saturates; the inductance stage first forms its product.
// The result sits in an output register: a new item is accepted while it
// waits, and a finished item holds in the controller until out_ready frees
// the register. Reset returns to the init stage, clears sums, results and
// the fault flag and loads the default configuration; no clearing pass.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
`default_nettype none
module motor_rl_identification_sequencer_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [31:0]              id_meas,
	input  wire logic signed [31:0]              iq_meas,
	input  wire logic signed [31:0]              vd_meas,
	input  wire logic signed [31:0]              vq_meas,
	input  wire logic [30:0]                     bus_volt,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 drive_mode,
	output logic signed [31:0]                   vd_ref,
	output logic [2:0]                           stage_now,
	output logic                                 all_done,
	output logic [31:0]                          resistance,
	output logic [31:0]                          inductance_nh,
	output logic                                 div_fault,
	input  wire logic                            cfg_we,
	input  wire logic [rlid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rlid_pkg::CFG_W-1:0]      cfg_data
);

	rlid_pkg::cmd_t    cmd;
	rlid_pkg::status_t status;

	rlid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	rlid_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.id_meas       (id_meas),
		.iq_meas       (iq_meas),
		.vd_meas       (vd_meas),
		.vq_meas       (vq_meas),
		.bus_volt      (bus_volt),
		.drive_mode    (drive_mode),
		.vd_ref        (vd_ref),
		.stage_now     (stage_now),
		.all_done      (all_done),
		.resistance    (resistance),
		.inductance_nh (inductance_nh),
		.div_fault     (div_fault)
	);

	a_done_stage: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (all_done == (stage_now == rlid_pkg::STG_DONE)))
		else $error("all_done disagrees with stage");

	a_off_no_volt: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !drive_mode) |-> (vd_ref == '0))
		else $error("voltage commanded while motor off");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item taken while one is in work");

endmodule
`default_nettype wire
